FILE: design/htsd_pkg.sv
// ----------------------------------------------------------------------------
// htsd_pkg
// types and constants shared by the huffman tree stream decoder
// ----------------------------------------------------------------------------
package htsd_pkg;

  typedef enum logic [5:0] {
    ST_HEADER = 6'b000001,
    ST_TREE   = 6'b000010,
    ST_LEAF   = 6'b000100,
    ST_DECODE = 6'b001000,
    ST_IDLE   = 6'b010000,
    ST_LOOKUP = 6'b100000
  } phase_e;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CountW = 16;

endpackage

FILE: design/huffman_tree_stream_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder
// decodes a byte stream carrying a pre-order huffman tree and its codes
// ----------------------------------------------------------------------------
//  channel  dir  tdata                 tuser
//  s_axis   in   [7:0] stream_byte     [0] image_start
//  m_axis   out  [7:0] decoded_byte    [0] tree_error, tlast = last_of_image
//  cfg      in   [15:0] output_count   (write enable only)
//
// a header or ignored byte is only accepted; a tree byte is accepted and its
// bits are then shifted out of the byte register, the input closed meanwhile.
// for a code byte each bit waits on a registered node table read, each leaf
// needs a read of its own, and the walk checks the node reached by the last
// bit before the input is ready again.
// reset is asynchronous; the node table and stack are not cleared.
// results sit in an output register; the bit loop stalls while it is full
// and resumes in the cycle after its beat leaves.
// ----------------------------------------------------------------------------
module huffman_tree_stream_decoder #(
  parameter int unsigned NODE_SLOTS   = 512,
  parameter int unsigned STACK_SLOTS  = 256,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        s_axis_tuser,   // [0] image_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] decoded_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] tree_error
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned NW = $clog2(NODE_SLOTS + 2);
  localparam int unsigned AW = $clog2(NODE_SLOTS);
  localparam int unsigned SW = $clog2(STACK_SLOTS + 1);
  localparam int unsigned SAW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
  localparam int unsigned HW = $clog2(HEADER_BYTES + 2);

  // node entry: [EW-1] internal flag, [NW-1:0] left child or [7:0] leaf value
  localparam int unsigned EW = (NW > 8) ? NW + 1 : 9;

  logic [EW-1:0] node_mem [NODE_SLOTS];
  logic [NW-1:0] stack_mem [STACK_SLOTS];
  logic [EW-1:0] rd_q;

  htsd_pkg::phase_e phase_q, phase_d;
  logic [15:0] count_q;
  logic [7:0]  sh_q, sh_d;
  logic [3:0]  bits_q, bits_d;
  logic [HW-1:0] hdr_q, hdr_d;
  logic [SW-1:0] sp_q, sp_d;
  logic [NW-1:0] nfree_q, nfree_d, cur_q, cur_d;
  logic [7:0]  leaf_q, leaf_d;
  logic [3:0]  lbits_q, lbits_d;
  logic        sep_q, sep_d;
  logic [15:0] written_q, written_d;
  logic        ov_q, ov_d;
  logic [7:0]  od_q, od_d;
  logic        ol_q, ol_d, oe_q, oe_d;

  logic        busy, bit_v, node_we, node_we2, st_we, rd_en;
  logic [NW-1:0] node_wa, rd_a;
  logic [EW-1:0] node_wd;
  logic [NW-1:0] st_rd_q;
  logic [15:0]   wr_inc;

  // a pending node read keeps the input closed even with no bits left
  assign busy = (bits_q != 4'd0) || (phase_q == htsd_pkg::ST_LOOKUP);
  assign bit_v = sh_q[7];
  assign s_axis_tready = !busy;
  assign wr_inc = written_q + 16'd1;

  always_comb begin
    phase_d = phase_q; sh_d = sh_q; bits_d = bits_q; hdr_d = hdr_q;
    sp_d = sp_q; nfree_d = nfree_q; cur_d = cur_q; leaf_d = leaf_q;
    lbits_d = lbits_q; sep_d = sep_q; written_d = written_q;
    ov_d = ov_q; od_d = od_q; ol_d = ol_q; oe_d = oe_q;
    node_we = 1'b0; node_we2 = 1'b0; node_wa = cur_q; node_wd = '0;
    st_we = 1'b0; rd_en = 1'b0; rd_a = cur_q;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    if (s_axis_tvalid && !busy) begin
      sh_d = s_axis_tdata;
      bits_d = 4'd8;
      if (s_axis_tuser) begin
        sp_d = '0; nfree_d = NW'(1); cur_d = '0; sep_d = 1'b0;
        written_d = '0; leaf_d = '0; lbits_d = '0; hdr_d = '0;
        phase_d = (HEADER_BYTES == 0) ? htsd_pkg::ST_TREE : htsd_pkg::ST_HEADER;
      end
      if (phase_d == htsd_pkg::ST_HEADER) begin
        bits_d = 4'd0;
        hdr_d = HW'(((s_axis_tuser ? '0 : hdr_q)) + HW'(1));
        if (32'(hdr_d) >= HEADER_BYTES) phase_d = htsd_pkg::ST_TREE;
      end else if (phase_d == htsd_pkg::ST_IDLE) begin
        bits_d = 4'd0;
      end else if (phase_d == htsd_pkg::ST_DECODE) begin
        phase_d = htsd_pkg::ST_LOOKUP;
        rd_en = 1'b1; rd_a = cur_d;
      end
    end else if (busy && !ov_q) begin
      unique case (phase_q)
        htsd_pkg::ST_TREE: begin
          sh_d = {sh_q[6:0], 1'b0}; bits_d = bits_q - 4'd1;
          if (sep_q) begin
            sep_d = 1'b0;
          end else if (!bit_v) begin
            if (32'(nfree_q) + 2 > NODE_SLOTS || 32'(sp_q) >= STACK_SLOTS) begin
              ov_d = 1'b1; od_d = '0; ol_d = 1'b0; oe_d = 1'b1;
              phase_d = htsd_pkg::ST_IDLE; bits_d = 4'd0;
            end else begin
              node_we = 1'b1; node_wa = cur_q;
              node_wd = {1'b1, {(EW-1-NW){1'b0}}, nfree_q};
              st_we = 1'b1;
              sp_d = sp_q + SW'(1);
              cur_d = nfree_q;
              nfree_d = nfree_q + NW'(2);
            end
          end else if (cur_q == '0) begin
            ov_d = 1'b1; od_d = '0; ol_d = 1'b0; oe_d = 1'b1;
            phase_d = htsd_pkg::ST_IDLE; bits_d = 4'd0;
          end else begin
            phase_d = htsd_pkg::ST_LEAF; leaf_d = '0; lbits_d = '0;
          end
        end
        htsd_pkg::ST_LEAF: begin
          sh_d = {sh_q[6:0], 1'b0}; bits_d = bits_q - 4'd1;
          leaf_d = {leaf_q[6:0], bit_v};
          lbits_d = lbits_q + 4'd1;
          if (lbits_q == 4'd7) begin
            node_we2 = 1'b1; node_wa = cur_q;
            node_wd = EW'({leaf_q[6:0], bit_v});
            if (sp_q == '0) begin
              cur_d = '0;
              if (count_q == '0) begin
                phase_d = htsd_pkg::ST_IDLE; bits_d = 4'd0;
              end else begin
                phase_d = htsd_pkg::ST_LOOKUP;
                rd_en = 1'b1; rd_a = '0;
              end
            end else begin
              sp_d = sp_q - SW'(1);
              cur_d = st_rd_q;
              sep_d = 1'b1;
              phase_d = htsd_pkg::ST_TREE;
            end
          end
        end
        htsd_pkg::ST_LOOKUP: begin
          // rd_q holds the entry of cur_q
          if (!rd_q[EW-1]) begin
            written_d = wr_inc;
            ov_d = 1'b1; od_d = rd_q[7:0]; oe_d = 1'b0;
            ol_d = wr_inc >= count_q;
            cur_d = '0;
            if (ol_d) begin
              phase_d = htsd_pkg::ST_IDLE; bits_d = 4'd0;
            end else begin
              rd_en = 1'b1; rd_a = '0;
            end
          end else if (bits_q == 4'd0) begin
            phase_d = htsd_pkg::ST_DECODE;
          end else begin
            cur_d = rd_q[NW-1:0] + NW'(bit_v);
            sh_d = {sh_q[6:0], 1'b0}; bits_d = bits_q - 4'd1;
            rd_en = 1'b1; rd_a = cur_d;
          end
        end
        default: bits_d = 4'd0;
      endcase
    end
  end

  // every node of a finished tree is written before the walk reads it
  always_ff @(posedge clk_i) begin
    if (node_we || node_we2) node_mem[AW'(node_wa)] <= node_wd;
    if (st_we) stack_mem[SAW'(sp_q)] <= nfree_q + NW'(1);
    if (rd_en) rd_q <= (32'(rd_a) >= NODE_SLOTS) ? '0 : node_mem[AW'(rd_a)];
    // stack top, settled long before a leaf completes
    st_rd_q <= stack_mem[SAW'(sp_q - SW'(1))];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= (HEADER_BYTES == 0) ? htsd_pkg::ST_TREE : htsd_pkg::ST_HEADER;
      count_q <= '0; sh_q <= '0; bits_q <= '0; hdr_q <= '0; sp_q <= '0;
      nfree_q <= NW'(1); cur_q <= '0; leaf_q <= '0; lbits_q <= '0;
      sep_q <= 1'b0; written_q <= '0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; sh_q <= sh_d; bits_q <= bits_d; hdr_q <= hdr_d;
      sp_q <= sp_d; nfree_q <= nfree_d; cur_q <= cur_d; leaf_q <= leaf_d;
      lbits_q <= lbits_d; sep_q <= sep_d; written_q <= written_d; ov_q <= ov_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d; ol_q <= ol_d; oe_q <= oe_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;
  assign m_axis_tlast = ol_q;
  assign m_axis_tuser = oe_q;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("error beat carries data");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("input taken while shifting");
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= STACK_SLOTS) else $error("stack pointer overflow");

endmodule
